### rtl/fsp_pkg.sv
package fsp_pkg;

  localparam int MAX_SLOTS_DEF = 1024;

  localparam int ADDR_W  = 32;
  localparam int BYTES_W = 23;
  localparam int SLOT_W  = 13;
  localparam int ALIGN_W = 8;
  localparam int COUNT_W = 11;
  localparam int CFG_W   = 32;
  localparam int DIVD_W  = 32;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] CFG_REGION_BASE  = 2'd0;
  localparam logic [1:0] CFG_REGION_BYTES = 2'd1;
  localparam logic [1:0] CFG_SLOT_BYTES   = 2'd2;
  localparam logic [1:0] CFG_SLOT_ALIGN   = 2'd3;

  localparam logic [BYTES_W-1:0] USED_MAX  = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] release_address;
  } fsp_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  slot_address;
    logic               granted;
    logic [BYTES_W-1:0] bytes_in_use;
    logic [COUNT_W-1:0] live_count;
  } fsp_out_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [SLOT_W-1:0] divisor;
  } fsp_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
    logic [SLOT_W-1:0] remainder;
  } fsp_div_res_t;

endpackage

### rtl/fsp_div.sv
module fsp_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fsp_pkg::fsp_div_req_t req,
  output fsp_pkg::fsp_div_res_t res
);

  localparam int CNT_W = $clog2(fsp_pkg::DIVD_W);

  logic [fsp_pkg::DIVD_W-1:0] quo_r, quo_nxt;
  logic [fsp_pkg::SLOT_W-1:0] rem_r, rem_nxt;
  logic [fsp_pkg::SLOT_W-1:0] div_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       run_r;
  logic                       done_r;
  logic [fsp_pkg::SLOT_W:0]   trial;
  logic                       ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial   = {rem_r, quo_r[fsp_pkg::DIVD_W-1]};
    ge      = (trial >= {1'b0, div_r});
    rem_nxt = ge ? fsp_pkg::SLOT_W'(trial - {1'b0, div_r}) : trial[fsp_pkg::SLOT_W-1:0];
    quo_nxt = {quo_r[fsp_pkg::DIVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(fsp_pkg::DIVD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      div_r <= req.divisor;
    end else if (run_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign res.done      = done_r;
  assign res.quotient  = quo_r;
  assign res.remainder = rem_r;

endmodule

### rtl/fsp_link_mem.sv
module fsp_link_mem #(
  parameter int DEPTH = fsp_pkg::MAX_SLOTS_DEF,
  parameter int AW    = $clog2(fsp_pkg::MAX_SLOTS_DEF),
  parameter int DW    = $clog2(fsp_pkg::MAX_SLOTS_DEF + 1) + 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/fixed_slot_pool_allocator.sv
// channel   ports                              handshake
// input     start, busy, in_data               taken when start high and busy low
// result    out_valid, out_data                one cycle per item, cannot be held off
// config    cfg_we, cfg_index, cfg_data        written when cfg_we high
//
// allocate: link memory read, then write-back and address add; a refused allocate finishes in the idle state
// free: a division by the 32-step shared divider, then one link memory read
// clear: a division by the shared divider, then one link memory write per slot to chain the link memory
// op 3 and a free or clear with nothing to do: finish in the idle state
// synchronous active-low reset; the link memory needs no clearing pass
// each result shows for one cycle after its item completes; the receiver cannot stall
module fixed_slot_pool_allocator #(
  parameter int MAX_SLOTS = fsp_pkg::MAX_SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  fsp_pkg::fsp_in_t          in_data,
  output logic                      out_valid,
  output fsp_pkg::fsp_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [fsp_pkg::CFG_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int LW = $clog2(MAX_SLOTS + 1);
  localparam int PW = AW + fsp_pkg::SLOT_W;
  localparam logic [LW-1:0] NULL_LINK = LW'(MAX_SLOTS);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ALLOC_RD = 3'd1;
  localparam logic [2:0] S_FREE_DIV = 3'd2;
  localparam logic [2:0] S_FREE_RD  = 3'd3;
  localparam logic [2:0] S_CLR_DIV  = 3'd4;
  localparam logic [2:0] S_CLR_SWP  = 3'd5;

  logic [fsp_pkg::ADDR_W-1:0]  region_base_r;
  logic [fsp_pkg::BYTES_W-1:0] region_bytes_r;
  logic [fsp_pkg::SLOT_W-1:0]  slot_bytes_r;
  logic [fsp_pkg::ALIGN_W-1:0] slot_align_r;

  logic [2:0]                  state_r, state_nxt;
  logic [LW-1:0]               head_r, head_nxt;
  logic [fsp_pkg::ADDR_W-1:0]  first_r, first_nxt;
  logic [fsp_pkg::SLOT_W-1:0]  pool_size_r, pool_size_nxt;
  logic [LW-1:0]               pool_slots_r, pool_slots_nxt;
  logic [fsp_pkg::BYTES_W-1:0] used_r, used_nxt;
  logic [fsp_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]               slot_idx_r, slot_idx_nxt;
  logic [AW-1:0]               sweep_r, sweep_nxt;
  logic [PW-1:0]               prod_r;
  logic                        out_valid_r;
  fsp_pkg::fsp_out_t           out_r;

  logic                        fin;
  logic                        fin_grant;
  logic [fsp_pkg::ADDR_W-1:0]  fin_addr;

  logic                        mem_we, mem_re;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic [LW:0]                 mem_wdata, mem_rdata;

  fsp_pkg::fsp_div_req_t       div_req;
  fsp_pkg::fsp_div_res_t       div_res;

  logic [fsp_pkg::ALIGN_W-1:0] pad_raw, pad;
  logic                        head_ok;
  logic [fsp_pkg::BYTES_W:0]   used_sum;
  logic [fsp_pkg::BYTES_W-1:0] used_add, used_sub;
  logic [fsp_pkg::COUNT_W-1:0] cnt_inc, cnt_dec;
  logic [LW-1:0]               sweep_next_idx;
  logic                        sweep_last;

  fsp_link_mem #(
    .DEPTH(MAX_SLOTS),
    .AW   (AW),
    .DW   (LW + 1)
  ) u_link_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  fsp_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .res  (div_res)
  );

  // alignment padding of the region start
  always_comb begin
    pad_raw = slot_align_r - (region_base_r[fsp_pkg::ALIGN_W-1:0] & (slot_align_r - 8'd1));
    pad     = ((slot_align_r == '0) || (pad_raw == slot_align_r)) ? '0 : pad_raw;
  end

  // saturating counters
  always_comb begin
    used_sum = {1'b0, used_r} + (fsp_pkg::BYTES_W + 1)'(pool_size_r);
    used_add = (used_sum > {1'b0, fsp_pkg::USED_MAX}) ? fsp_pkg::USED_MAX
                                                      : used_sum[fsp_pkg::BYTES_W-1:0];
    used_sub = (used_r > fsp_pkg::BYTES_W'(pool_size_r))
             ? used_r - fsp_pkg::BYTES_W'(pool_size_r) : '0;
    cnt_inc  = (cnt_r < fsp_pkg::COUNT_MAX) ? cnt_r + 11'd1 : cnt_r;
    cnt_dec  = (cnt_r != '0) ? cnt_r - 11'd1 : cnt_r;
  end

  assign head_ok        = (head_r < pool_slots_r);
  assign sweep_next_idx = LW'(sweep_r) + LW'(1);
  assign sweep_last     = (sweep_next_idx == pool_slots_r);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    first_nxt      = first_r;
    pool_size_nxt  = pool_size_r;
    pool_slots_nxt = pool_slots_r;
    used_nxt       = used_r;
    cnt_nxt        = cnt_r;
    slot_idx_nxt   = slot_idx_r;
    sweep_nxt      = sweep_r;
    fin            = 1'b0;
    fin_grant      = 1'b0;
    fin_addr       = '0;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    div_req        = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_data.op)
            fsp_pkg::OP_ALLOC: begin
              if (head_ok) begin
                mem_re    = 1'b1;
                mem_raddr = head_r[AW-1:0];
                state_nxt = S_ALLOC_RD;
              end else begin
                fin = 1'b1;
              end
            end
            fsp_pkg::OP_FREE: begin
              if ((pool_size_r != '0) && (pool_slots_r != '0)) begin
                div_req.start    = 1'b1;
                div_req.dividend = in_data.release_address - first_r;
                div_req.divisor  = pool_size_r;
                state_nxt        = S_FREE_DIV;
              end else begin
                fin = 1'b1;
              end
            end
            fsp_pkg::OP_CLEAR: begin
              first_nxt     = region_base_r + fsp_pkg::ADDR_W'(pad);
              pool_size_nxt = slot_bytes_r;
              if ((slot_bytes_r != '0) && (region_bytes_r >= fsp_pkg::BYTES_W'(pad))) begin
                div_req.start    = 1'b1;
                div_req.dividend = fsp_pkg::DIVD_W'(region_bytes_r - fsp_pkg::BYTES_W'(pad));
                div_req.divisor  = slot_bytes_r;
                state_nxt        = S_CLR_DIV;
              end else begin
                pool_slots_nxt = '0;
                head_nxt       = NULL_LINK;
                fin            = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_ALLOC_RD: begin
        mem_we    = 1'b1;
        mem_waddr = head_r[AW-1:0];
        mem_wdata = {1'b1, mem_rdata[LW-1:0]};
        head_nxt  = mem_rdata[LW-1:0];
        used_nxt  = used_add;
        cnt_nxt   = cnt_inc;
        fin       = 1'b1;
        fin_grant = 1'b1;
        fin_addr  = first_r + fsp_pkg::ADDR_W'(prod_r);
        state_nxt = S_IDLE;
      end
      S_FREE_DIV: begin
        if (div_res.done) begin
          if ((div_res.remainder == '0)
              && (div_res.quotient < fsp_pkg::DIVD_W'(pool_slots_r))) begin
            mem_re       = 1'b1;
            mem_raddr    = div_res.quotient[AW-1:0];
            slot_idx_nxt = div_res.quotient[AW-1:0];
            state_nxt    = S_FREE_RD;
          end else begin
            fin       = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_FREE_RD: begin
        // ignored unless the slot is in use
        if (mem_rdata[LW]) begin
          mem_we    = 1'b1;
          mem_waddr = slot_idx_r;
          mem_wdata = {1'b0, head_r};
          head_nxt  = LW'(slot_idx_r);
          used_nxt  = used_sub;
          cnt_nxt   = cnt_dec;
        end
        fin       = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CLR_DIV: begin
        if (div_res.done) begin
          if (div_res.quotient == '0) begin
            pool_slots_nxt = '0;
            head_nxt       = NULL_LINK;
            fin            = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            pool_slots_nxt = (div_res.quotient > fsp_pkg::DIVD_W'(MAX_SLOTS))
                           ? NULL_LINK : div_res.quotient[LW-1:0];
            sweep_nxt      = '0;
            state_nxt      = S_CLR_SWP;
          end
        end
      end
      S_CLR_SWP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r;
        mem_wdata = {1'b0, sweep_last ? NULL_LINK : sweep_next_idx};
        if (sweep_last) begin
          head_nxt  = '0;
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          sweep_nxt = sweep_r + AW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_base_r  <= '0;
      region_bytes_r <= '0;
      slot_bytes_r   <= 13'd8;
      slot_align_r   <= 8'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        fsp_pkg::CFG_REGION_BASE:  region_base_r  <= cfg_data[fsp_pkg::ADDR_W-1:0];
        fsp_pkg::CFG_REGION_BYTES: region_bytes_r <= cfg_data[fsp_pkg::BYTES_W-1:0];
        fsp_pkg::CFG_SLOT_BYTES:   slot_bytes_r   <= cfg_data[fsp_pkg::SLOT_W-1:0];
        fsp_pkg::CFG_SLOT_ALIGN:   slot_align_r   <= cfg_data[fsp_pkg::ALIGN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= NULL_LINK;
      first_r      <= '0;
      pool_size_r  <= '0;
      pool_slots_r <= '0;
      used_r       <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      first_r      <= first_nxt;
      pool_size_r  <= pool_size_nxt;
      pool_slots_r <= pool_slots_nxt;
      used_r       <= used_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    slot_idx_r <= slot_idx_nxt;
    sweep_r    <= sweep_nxt;
    prod_r     <= PW'(head_r[AW-1:0]) * PW'(pool_size_r);
    if (fin) begin
      out_r.slot_address <= fin_addr;
      out_r.granted      <= fin_grant;
      out_r.bytes_in_use <= used_nxt;
      out_r.live_count   <= cnt_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_out_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start) || $past(state_r != S_IDLE)))
    else $error("result without an item");

  a_grant_from_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.granted) |-> $past(state_r == S_ALLOC_RD))
    else $error("grant outside allocate");

  a_head_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_IDLE) && (head_r != NULL_LINK)) |-> (head_r < pool_slots_r))
    else $error("free list head outside pool");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> ((state_r == S_FREE_DIV) || (state_r == S_CLR_DIV)))
    else $error("divider result with no user");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r != S_IDLE))
    else $error("link memory written while idle");

endmodule
